// ===== sv/dstc_pkg.sv =====
// Shared types, constants and lookup functions for the divider sensor temperature converter.
package dstc_pkg;

    localparam int MV_W      = 12;
    localparam int PULLUP_W  = 17;
    localparam int TEMP_W    = 16;
    localparam int NUM_W     = MV_W + PULLUP_W;
    localparam int R_W       = 12;
    localparam int REM_W     = MV_W + R_W;
    localparam int DSH_W     = MV_W + R_W - 1;
    localparam int DIV_STEPS = R_W;
    localparam int BAND_W    = 3;
    localparam int COEF_W    = 7;
    localparam int RECIP_W   = 16;
    localparam int X_W       = 22;
    localparam int PROD_W    = X_W + RECIP_W;
    localparam int Q_W       = 16;

    localparam logic [MV_W-1:0]     SUPPLY_MV    = 12'd3300;
    localparam logic [PULLUP_W-1:0] PULLUP_RESET = 17'd1000;
    localparam logic [R_W-1:0]      NOMINAL_OHMS = 12'd1000;
    localparam logic [9:0]          MILLI        = 10'd1000;
    localparam logic [Q_W-1:0]      RISE_LIMIT   = 16'd19900;

    localparam logic signed [TEMP_W-1:0] BASE_CENTIDEG = 16'sd2500;
    localparam logic signed [TEMP_W-1:0] OPEN_CENTIDEG = 16'sd22400;
    localparam logic signed [TEMP_W-1:0] MIN_CENTIDEG  = -16'sd8863;

    // One word in flight through the divider.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DSH_W-1:0] den_sh;
        logic [R_W-1:0]   quo;
        logic             sat;
        logic             open;
    } dstc_div_t;

    function automatic logic [BAND_W-1:0] band_of(input logic [R_W-1:0] r);
        logic [BAND_W-1:0] b;
        begin
            if (r < 12'd802)
                b = 3'd0;
            else if (r < 12'd874)
                b = 3'd1;
            else if (r < 12'd950)
                b = 3'd2;
            else if (r < 12'd990)
                b = 3'd3;
            else if (r < 12'd1029)
                b = 3'd4;
            else if (r < 12'd1108)
                b = 3'd5;
            else if (r < 12'd1192)
                b = 3'd6;
            else
                b = 3'd7;
            return b;
        end
    endfunction

    // Slope in tenths of an ohm per degree.
    function automatic logic [COEF_W-1:0] coef_of(input logic [BAND_W-1:0] b);
        logic [COEF_W-1:0] c;
        begin
            case (b)
                3'd0:    c = 7'd88;
                3'd1:    c = 7'd85;
                3'd2:    c = 7'd83;
                3'd3:    c = 7'd80;
                3'd4:    c = 7'd79;
                3'd5:    c = 7'd78;
                3'd6:    c = 7'd75;
                default: c = 7'd73;
            endcase
            return c;
        end
    endfunction

    // floor(2^22 / coef); result is low by at most one.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [BAND_W-1:0] b);
        logic [RECIP_W-1:0] m;
        begin
            case (b)
                3'd0:    m = 16'd47662;
                3'd1:    m = 16'd49344;
                3'd2:    m = 16'd50533;
                3'd3:    m = 16'd52428;
                3'd4:    m = 16'd53092;
                3'd5:    m = 16'd53773;
                3'd6:    m = 16'd55924;
                default: m = 16'd57456;
            endcase
            return m;
        end
    endfunction

endpackage

// ===== sv/dstc_if.sv =====
// Handshake interfaces for the sample, result and configuration channels.
interface dstc_in_if;
    logic                         valid;
    logic                         ready;
    logic [dstc_pkg::MV_W-1:0]    adc_millivolts;

    modport source (output valid, output adc_millivolts, input ready);
    modport sink   (input valid, input adc_millivolts, output ready);
endinterface

interface dstc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [dstc_pkg::TEMP_W-1:0] temp_centideg;
    logic                               open_sensor;

    modport source (output valid, output temp_centideg, output open_sensor, input ready);
    modport sink   (input valid, input temp_centideg, input open_sensor, output ready);
endinterface

interface dstc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dstc_pkg::PULLUP_W-1:0]   pullup_ohms;

    modport source (output valid, output pullup_ohms, input ready);
    modport sink   (input valid, input pullup_ohms, output ready);
endinterface

// ===== sv/divider_sensor_temperature_convert.sv =====
// Top level of the divider sensor temperature converter.
// Takes one millivolt word per cycle while sample.ready is high and returns one temperature
// word per input, in order, through 2 front stages (product, range check), 12 restoring
// divider stages (one quotient bit each) and 5 back stages (band, scale, reciprocal multiply,
// correction, result register). Every stage has its own valid bit and a ready that opens
// when the stage is empty, so bubbles close up under output stalls. A sample at or above
// 3300 mV returns 224.00 degrees with open_sensor set. pullup_ohms resets to 1000; the user
// is to write it through cfg only while no word is in flight, as the block does not enforce this.
module divider_sensor_temperature_convert (
    input  logic          clk,
    input  logic          rst_n,
    dstc_cfg_if.sink      cfg,
    dstc_in_if.sink       sample,
    dstc_out_if.source    result
);

    logic [dstc_pkg::PULLUP_W-1:0] pullup_reg;

    logic                  st_valid [dstc_pkg::DIV_STEPS+1];
    logic                  st_ready [dstc_pkg::DIV_STEPS+1];
    dstc_pkg::dstc_div_t   st_word  [dstc_pkg::DIV_STEPS+1];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pullup_reg <= dstc_pkg::PULLUP_RESET;
        else if (cfg.valid)
            pullup_reg <= cfg.pullup_ohms;
    end

    dstc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pullup_ohms (pullup_reg),
        .sample      (sample),
        .out_valid   (st_valid[0]),
        .out_ready   (st_ready[0]),
        .out_word    (st_word[0])
    );

    for (genvar i = 0; i < dstc_pkg::DIV_STEPS; i++)
    begin : g_div
        dstc_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[i]),
            .in_ready  (st_ready[i]),
            .in_word   (st_word[i]),
            .out_valid (st_valid[i+1]),
            .out_ready (st_ready[i+1]),
            .out_word  (st_word[i+1])
        );
    end

    dstc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (st_valid[dstc_pkg::DIV_STEPS]),
        .in_ready (st_ready[dstc_pkg::DIV_STEPS]),
        .in_word  (st_word[dstc_pkg::DIV_STEPS]),
        .result   (result)
    );

    a_open_value: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.open_sensor |-> result.temp_centideg == dstc_pkg::OPEN_CENTIDEG)
        else $error("open sensor word without clamp value");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.temp_centideg >= dstc_pkg::MIN_CENTIDEG)
                      && (result.temp_centideg <= dstc_pkg::OPEN_CENTIDEG))
        else $error("temperature out of range");

    // after the last step the shifted divisor has left the upper bits
    a_div_final: assert property (@(posedge clk) disable iff (!rst_n)
        st_valid[dstc_pkg::DIV_STEPS]
        |-> st_word[dstc_pkg::DIV_STEPS].den_sh[dstc_pkg::DSH_W-1:dstc_pkg::MV_W-1] == '0)
        else $error("divider stage count mismatch");

endmodule

// ===== sv/dstc_front.sv =====
// Front end: divider product, denominator, open check and quotient range check.
module dstc_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [dstc_pkg::PULLUP_W-1:0]     pullup_ohms,
    dstc_in_if.sink                           sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output dstc_pkg::dstc_div_t               out_word
);

    logic                          v0_reg;
    logic [dstc_pkg::NUM_W-1:0]    num_reg;
    logic [dstc_pkg::MV_W-1:0]     den_reg;
    logic                          open0_reg;
    logic                          rdy0;

    logic                          v1_reg;
    dstc_pkg::dstc_div_t           word_reg;
    dstc_pkg::dstc_div_t           word_next;
    logic                          rdy1;

    logic [dstc_pkg::NUM_W-1:0]    num_next;

    assign rdy1 = !v1_reg || out_ready;
    assign rdy0 = !v0_reg || rdy1;
    assign sample.ready = rdy0;

    assign num_next = {{dstc_pkg::PULLUP_W{1'b0}}, sample.adc_millivolts}
                    * {{dstc_pkg::MV_W{1'b0}}, pullup_ohms};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= sample.valid;
            if (rdy1)
                v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0)
        begin
            num_reg   <= num_next;
            den_reg   <= dstc_pkg::SUPPLY_MV - sample.adc_millivolts;
            open0_reg <= (sample.adc_millivolts >= dstc_pkg::SUPPLY_MV);
        end
        if (rdy1)
            word_reg <= word_next;
    end

    // Quotient of 4096 or more always clamps, so only 12 quotient bits are formed.
    always_comb
    begin
        word_next.rem    = num_reg[dstc_pkg::REM_W-1:0];
        word_next.den_sh = {den_reg, {(dstc_pkg::R_W-1){1'b0}}};
        word_next.quo    = '0;
        word_next.sat    = (num_reg >= {{(dstc_pkg::NUM_W-dstc_pkg::REM_W){1'b0}},
                                        den_reg, {dstc_pkg::R_W{1'b0}}});
        word_next.open   = open0_reg;
    end

    assign out_valid = v1_reg;
    assign out_word  = word_reg;

endmodule

// ===== sv/dstc_div_stage.sv =====
// One restoring division step: one quotient bit per stage.
module dstc_div_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  dstc_pkg::dstc_div_t    in_word,
    output logic                   out_valid,
    input  logic                   out_ready,
    output dstc_pkg::dstc_div_t    out_word
);

    logic                   v_reg;
    dstc_pkg::dstc_div_t    word_reg;
    dstc_pkg::dstc_div_t    word_next;
    logic                   ge;

    assign in_ready = !v_reg || out_ready;

    assign ge = (in_word.rem >= {1'b0, in_word.den_sh});

    always_comb
    begin
        word_next        = in_word;
        word_next.rem    = ge ? (in_word.rem - {1'b0, in_word.den_sh}) : in_word.rem;
        word_next.den_sh = in_word.den_sh >> 1;
        word_next.quo    = {in_word.quo[dstc_pkg::R_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            word_reg <= word_next;
    end

    assign out_valid = v_reg;
    assign out_word  = word_reg;

endmodule

// ===== sv/dstc_back.sv =====
// Back end: slope band, scaled rise by reciprocal multiply, clamp and result register.
module dstc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  dstc_pkg::dstc_div_t    in_word,
    dstc_out_if.source             result
);

    // B1: magnitude of R - 1000, sign, band
    logic                              v1_reg, rdy1;
    logic [dstc_pkg::R_W-1:0]          d1_reg;
    logic [dstc_pkg::BAND_W-1:0]       b1_reg;
    logic                              neg1_reg, sat1_reg, open1_reg;

    // B2: x = |d| * 1000
    logic                              v2_reg, rdy2;
    logic [dstc_pkg::X_W-1:0]          x2_reg;
    logic [dstc_pkg::BAND_W-1:0]       b2_reg;
    logic                              neg2_reg, sat2_reg, open2_reg;

    // B3: estimate q = x * recip >> 22
    logic                              v3_reg, rdy3;
    logic [dstc_pkg::X_W-1:0]          x3_reg;
    logic [dstc_pkg::Q_W-1:0]          q3_reg;
    logic [dstc_pkg::BAND_W-1:0]       b3_reg;
    logic                              neg3_reg, sat3_reg, open3_reg;

    // B4: correct estimate by one
    logic                              v4_reg, rdy4;
    logic [dstc_pkg::Q_W-1:0]          q4_reg;
    logic                              neg4_reg, sat4_reg, open4_reg;

    // B5: result register
    logic                              v5_reg, rdy5;
    logic signed [dstc_pkg::TEMP_W-1:0] temp5_reg;
    logic                              open5_reg;

    logic                              neg_c;
    logic [dstc_pkg::R_W-1:0]          d_c;
    logic [dstc_pkg::X_W-1:0]          x_c;
    logic [dstc_pkg::PROD_W-1:0]       p_c;
    logic [dstc_pkg::COEF_W-1:0]       coef_c;
    logic [dstc_pkg::X_W-1:0]          qc_c;
    logic [dstc_pkg::X_W-1:0]          rmd_c;
    logic [dstc_pkg::Q_W-1:0]          q_c;
    logic signed [dstc_pkg::TEMP_W-1:0] qs_c;
    logic signed [dstc_pkg::TEMP_W-1:0] temp_c;

    assign rdy5 = !v5_reg || result.ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign neg_c = (in_word.quo < dstc_pkg::NOMINAL_OHMS);
    assign d_c   = neg_c ? (dstc_pkg::NOMINAL_OHMS - in_word.quo)
                         : (in_word.quo - dstc_pkg::NOMINAL_OHMS);

    assign x_c = {{(dstc_pkg::X_W-dstc_pkg::R_W){1'b0}}, d1_reg}
               * {{(dstc_pkg::X_W-10){1'b0}}, dstc_pkg::MILLI};

    assign p_c = {{dstc_pkg::RECIP_W{1'b0}}, x2_reg}
               * {{dstc_pkg::X_W{1'b0}}, dstc_pkg::recip_of(b2_reg)};

    assign coef_c = dstc_pkg::coef_of(b3_reg);
    assign qc_c   = {{(dstc_pkg::X_W-dstc_pkg::Q_W){1'b0}}, q3_reg}
                  * {{(dstc_pkg::X_W-dstc_pkg::COEF_W){1'b0}}, coef_c};
    assign rmd_c  = x3_reg - qc_c;
    assign q_c    = (rmd_c >= {{(dstc_pkg::X_W-dstc_pkg::COEF_W){1'b0}}, coef_c})
                  ? (q3_reg + 16'd1) : q3_reg;

    assign qs_c = $signed(q4_reg);

    always_comb
    begin
        if (open4_reg || sat4_reg || (!neg4_reg && (q4_reg > dstc_pkg::RISE_LIMIT)))
            temp_c = dstc_pkg::OPEN_CENTIDEG;
        else if (neg4_reg)
            temp_c = dstc_pkg::BASE_CENTIDEG - qs_c;
        else
            temp_c = dstc_pkg::BASE_CENTIDEG + qs_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
            if (rdy5)
                v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            d1_reg    <= d_c;
            b1_reg    <= dstc_pkg::band_of(in_word.quo);
            neg1_reg  <= neg_c;
            sat1_reg  <= in_word.sat;
            open1_reg <= in_word.open;
        end
        if (rdy2)
        begin
            x2_reg    <= x_c;
            b2_reg    <= b1_reg;
            neg2_reg  <= neg1_reg;
            sat2_reg  <= sat1_reg;
            open2_reg <= open1_reg;
        end
        if (rdy3)
        begin
            x3_reg    <= x2_reg;
            q3_reg    <= p_c[dstc_pkg::PROD_W-1:dstc_pkg::X_W];
            b3_reg    <= b2_reg;
            neg3_reg  <= neg2_reg;
            sat3_reg  <= sat2_reg;
            open3_reg <= open2_reg;
        end
        if (rdy4)
        begin
            q4_reg    <= q_c;
            neg4_reg  <= neg3_reg;
            sat4_reg  <= sat3_reg;
            open4_reg <= open3_reg;
        end
        if (rdy5)
        begin
            temp5_reg <= temp_c;
            open5_reg <= open4_reg;
        end
    end

    assign result.valid         = v5_reg;
    assign result.temp_centideg = temp5_reg;
    assign result.open_sensor   = open5_reg;

endmodule
